// ----- rtl/url_percent_decoder_defines.svh -----
// Assertion macros shared by the URL percent decoder RTL.
`ifndef URL_PERCENT_DECODER_DEFINES_SVH
`define URL_PERCENT_DECODER_DEFINES_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define UPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("url_percent_decoder assertion failed");
// Check a property on every clock edge, reset included.
`define UPD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("url_percent_decoder assertion failed");
`else
`define UPD_ASSERT(lbl, prop)
`define UPD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- rtl/upd_pkg.sv -----
// Types, constants and helper functions of the URL percent decoder.
`timescale 1ns / 1ps
`default_nettype none

package upd_pkg;

  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_empty;
  } out_item_t;

  // One step of the decoder: whether a result comes out, and which.
  typedef struct packed {
    logic      emit;
    out_item_t item;
  } step_res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_val(input logic [7:0] c);
    hex_digit_t d;
    d.ok  = 1'b1;
    d.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.val = 4'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.val = 4'(c - 8'h41 + 8'd10);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] plus_to_space(input logic [7:0] c);
    return (c == CHAR_PLUS) ? CHAR_SPACE : c;
  endfunction

  // Escape value of one or two bytes, strtol style, wrapped to 8 bits.
  function automatic logic [7:0] esc_value(input logic [7:0] c1, input logic [7:0] c2,
                                           input logic two);
    hex_digit_t h1;
    hex_digit_t h2;
    logic [7:0] v;
    h1 = hex_val(c1);
    h2 = hex_val(c2);
    h2.ok = h2.ok & two;
    v = 8'd0;
    if (h1.ok) begin
      v = h2.ok ? 8'({h1.val, h2.val}) : {4'd0, h1.val};
    end else if (is_ws(c1) && h2.ok) begin
      v = {4'd0, h2.val};
    end else if (c1 == CHAR_MINUS && h2.ok) begin
      v = 8'(9'd0 - {5'd0, h2.val});
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/url_percent_decoder.sv -----
// Top level of the streaming URL percent decoder.
`timescale 1ns / 1ps
`default_nettype none
`include "url_percent_decoder_defines.svh"

// Decodes a URL string one byte per beat: '+' becomes a space, "%%" gives '%',
// and '%' with up to two following bytes gives the hex value of the escape
// (zero values are dropped). Each input beat yields zero or one output beat;
// the beat marked last always yields a result marked last, empty if it carries
// no byte. Throughput is one byte per cycle while out_ready does not stall the
// output; each byte passes the input register and then the output register,
// with the escape state updated as a byte moves from the first to the second.
module url_percent_decoder (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire upd_pkg::in_item_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      upd_pkg::out_item_t out_data
);

  logic               s1_valid;
  upd_pkg::in_item_t  s1_data;
  logic               adv;
  upd_pkg::step_res_t res;

  // Advance the held byte whenever the output register is free or draining.
  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  upd_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (adv),
    .cur  (s1_data),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (adv) begin
        out_valid <= res.emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
    if (adv && res.emit) begin
      out_data <= res.item;
    end
  end

  `UPD_ASSERT(a_empty_is_zero,
    out_valid && out_data.out_empty |-> out_data.out_byte == 8'd0 && out_data.out_last)
  `UPD_ASSERT(a_last_emits, adv && s1_data.in_last |-> res.emit)
  `UPD_ASSERT(a_no_stall_when_free, s1_valid && !out_valid |-> in_ready)
  `UPD_ASSERT_ALWAYS(a_reset_clears, $past(rst) |-> !s1_valid && !out_valid)

endmodule

`default_nettype wire

// ----- rtl/upd_core.sv -----
// Escape state machine: decodes one byte per step and holds escape state.
`timescale 1ns / 1ps
`default_nettype none

module upd_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire upd_pkg::in_item_t  cur,
  output upd_pkg::step_res_t      res
);

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_PCT   = 2'd1,
    PH_HOLD  = 2'd2
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] first_char;
  logic [7:0] first_char_next;
  logic [7:0] c_sp;
  logic [7:0] b;
  logic       data;

  assign c_sp = upd_pkg::plus_to_space(cur.in_byte);

  always_comb begin
    phase_next      = phase;
    first_char_next = first_char;
    b               = 8'd0;
    data            = 1'b0;
    unique case (phase)
      PH_PCT: begin
        if (cur.in_byte == upd_pkg::CHAR_PERCENT) begin
          b          = upd_pkg::CHAR_PERCENT;
          data       = 1'b1;
          phase_next = PH_PLAIN;
        end else if (cur.in_last) begin
          b          = upd_pkg::esc_value(c_sp, 8'd0, 1'b0);
          data       = (b != 8'd0);
          phase_next = PH_PLAIN;
        end else begin
          first_char_next = c_sp;
          phase_next      = PH_HOLD;
        end
      end
      PH_HOLD: begin
        b          = upd_pkg::esc_value(first_char, c_sp, 1'b1);
        data       = (b != 8'd0);
        phase_next = PH_PLAIN;
      end
      default: begin
        if (cur.in_byte == upd_pkg::CHAR_PERCENT) begin
          phase_next = PH_PCT;
        end else begin
          b          = c_sp;
          data       = 1'b1;
          phase_next = PH_PLAIN;
        end
      end
    endcase
    // Last beat closes the string.
    if (cur.in_last) begin
      phase_next      = PH_PLAIN;
      first_char_next = 8'd0;
    end
    res.emit           = data | cur.in_last;
    res.item.out_byte  = data ? b : 8'd0;
    res.item.out_last  = cur.in_last;
    res.item.out_empty = ~data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_PLAIN;
      first_char <= 8'd0;
    end else if (step) begin
      phase      <= phase_next;
      first_char <= first_char_next;
    end
  end

endmodule

`default_nettype wire
